### src/ssu_pkg.sv
// ============================================================================
// ssu_pkg
// Shared types for the selection sorter: sequencer state codes.
// ============================================================================
package ssu_pkg;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_COLLECT = 3'b001,
    S_SCAN    = 3'b010,
    S_EMIT    = 3'b100
  } ssu_state_e;

endpackage

### src/selection_sorter_unit.sv
// ============================================================================
// selection_sorter_unit
// Collects signed words into a store and, on the last word of a set, emits
// the set in ascending order by selection sort over the store.
// ============================================================================
// Collect: one input word per cycle, no results.
// Sort: pass i reads entries i..n-1 (one read per cycle, registered read),
//   keeps the least, and emits it as one output word; the next pass starts
//   once that word is taken, and the last pass ends the set.
// Reset clears the sequencer, item count and drop flag; store contents are
//   left undefined and need no clearing pass.
module selection_sorter_unit import ssu_pkg::*; #(
  parameter int MAX_ITEMS  = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic                  last_in_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic [DATA_WIDTH-1:0] sorted_value_o,
  output logic                  last_out_o,
  output logic                  overflowed_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] One      = CW'(1);

  ssu_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic dropped_q, dropped_d;
  logic [CW-1:0] pass_q, pass_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] cmp_idx_q, cmp_idx_d;
  logic cmp_vld_q, cmp_vld_d;
  logic [DATA_WIDTH-1:0] min_q, min_d;
  logic [DATA_WIDTH-1:0] first_q, first_d;
  logic [AW-1:0] pick_q, pick_d;
  logic out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] out_value_q;
  logic out_last_q, out_ovf_q;
  logic out_load;

  logic in_acc, out_acc;
  logic rd_en;
  logic we;
  logic [AW-1:0] waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;
  logic first_elem, take, scan_done;

  assign in_ready_o = (state_q == S_COLLECT);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_q && out_ready_i;

  // Issue store reads while the pass still has entries to visit
  assign rd_en = (state_q == S_SCAN) && (rd_idx_q < count_q);

  // Compare the returning word against the running minimum
  assign first_elem = cmp_vld_q && (cmp_idx_q == pass_q);
  assign take       = first_elem || (cmp_vld_q && ($signed(rdata) < $signed(min_q)));
  assign scan_done  = cmp_vld_q && (cmp_idx_q == (count_q - One));

  // Store writes: append on collect, swap the displaced word on emit
  always_comb begin
    we    = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = value_i;
    if (in_acc && (count_q < MaxCount)) begin
      we = 1'b1;
    end else if ((state_q == S_EMIT) && out_acc) begin
      we    = 1'b1;
      waddr = pick_q;
      wdata = first_q;
    end
  end

  ssu_store #(
    .Depth(MAX_ITEMS),
    .Width(DATA_WIDTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (rd_en),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    pass_d      = pass_q;
    rd_idx_d    = rd_idx_q;
    cmp_vld_d   = rd_en;
    cmp_idx_d   = rd_idx_q;
    min_d       = min_q;
    first_d     = first_q;
    pick_d      = pick_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;

    if (rd_en) begin
      rd_idx_d = rd_idx_q + One;
    end
    if (take) begin
      min_d  = rdata;
      pick_d = cmp_idx_q[AW-1:0];
    end
    if (first_elem) begin
      first_d = rdata;
    end

    case (state_q)
      S_COLLECT: begin
        if (in_acc) begin
          if (count_q < MaxCount) begin
            count_d = count_q + One;
          end else begin
            dropped_d = 1'b1;
          end
          if (last_in_i) begin
            state_d  = S_SCAN;
            pass_d   = '0;
            rd_idx_d = '0;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            count_d   = '0;
            dropped_d = 1'b0;
            state_d   = S_COLLECT;
          end else begin
            pass_d   = pass_q + One;
            rd_idx_d = pass_q + One;
            state_d  = S_SCAN;
          end
        end
      end
      default: begin
        state_d = S_COLLECT;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_COLLECT;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      pass_q      <= '0;
      rd_idx_q    <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      pass_q      <= pass_d;
      rd_idx_q    <= rd_idx_d;
      cmp_idx_q   <= cmp_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers: running minimum, its index, the pass's first word and output word
  always_ff @(posedge clk_i) begin
    min_q   <= min_d;
    first_q <= first_d;
    pick_q  <= pick_d;
    if (out_load) begin
      out_value_q <= min_d;
      out_last_q  <= (pass_q == (count_q - One));
      out_ovf_q   <= dropped_q;
    end
  end

  assign sorted_value_o = out_value_q;
  assign last_out_o     = out_last_q;
  assign overflowed_o   = out_ovf_q;
  assign out_valid_o    = out_valid_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount)
    else $error("item count above capacity");

  a_cmp_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (cmp_idx_q < count_q) && (cmp_idx_q >= pass_q))
    else $error("compare index outside current pass");

  a_valid_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_EMIT))
    else $error("output word valid outside emit");

  a_set_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_last_q) |=> (count_q == '0) && !dropped_q && in_ready_o)
    else $error("set not cleared after final word");

  a_next_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !out_last_q) |=> (state_q == S_SCAN) && (rd_idx_q == pass_q))
    else $error("next pass not started after word taken");

endmodule

### src/ssu_store.sv
// ============================================================================
// ssu_store
// Item store: single write port, single read port, registered read.
// ============================================================================
module ssu_store import ssu_pkg::*; #(
  parameter int Depth = 32,
  parameter int Width = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### verif/tb_selection_sorter_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_selection_sorter_unit
// Streams sets of signed words into the selection sorter and checks every
// sorted word, its end-of-set flag and its overflow flag against a local
// model of the store. Directed sets cover the value extremes, single-word
// sets, duplicates and presorted and reversed input. Random sets follow,
// including sets that exactly fill the store and sets that overrun it. Both
// sides insert random bursts of idle cycles.
// ============================================================================
module tb_selection_sorter_unit;

  localparam int    DW        = 32;
  localparam int    CAPACITY  = 32;
  localparam int    GAP_MAX   = 14;
  localparam int    RAND_WORDS = 420;
  localparam int    DRAIN_CYC = CAPACITY * CAPACITY / 2 + 2 * CAPACITY;
  localparam int    MAX_PRINT = 40;

  typedef logic signed [DW-1:0] sval_t;

  localparam sval_t VAL_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam sval_t VAL_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct {
    sval_t value;
    logic  last;
  } in_word_t;

  typedef struct {
    sval_t value;
    logic  last;
    logic  dropped;
  } out_word_t;

  // DUT ports, inputs known from time zero
  logic          clk_i          = 1'b0;
  logic          rst_ni         = 1'b0;
  logic [DW-1:0] value_i        = '0;
  logic          last_in_i      = 1'b0;
  logic          in_valid_i     = 1'b0;
  logic          in_ready_o;
  logic [DW-1:0] sorted_value_o;
  logic          last_out_o;
  logic          overflowed_o;
  logic          out_valid_o;
  logic          out_ready_i    = 1'b0;

  // Stimulus and prediction state
  in_word_t    pend_q [$];
  out_word_t   sorted_due_q [$];
  sval_t       set_store [CAPACITY];
  int unsigned set_count   = 0;
  logic        set_dropped = 1'b0;
  logic        calm        = 1'b0;
  int          gap_left    = 0;
  int          stall_left  = 0;
  int          err_count   = 0;
  int          words_taken = 0;
  int          sets_closed = 0;
  int          sets_overrun = 0;
  int          results_seen = 0;

  selection_sorter_unit #(
    .MAX_ITEMS  (CAPACITY),
    .DATA_WIDTH (DW)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (value_i),
    .last_in_i      (last_in_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sorted_value_o (sorted_value_o),
    .last_out_o     (last_out_o),
    .overflowed_o   (overflowed_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINT) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  function automatic void add_word(input sval_t v, input logic last);
    in_word_t w;
    w.value = v;
    w.last  = last;
    pend_q.push_back(w);
  endfunction

  // Store an accepted word; on the closing word sort the set and queue its output
  function automatic void take_word(input in_word_t w);
    int        i, j, pick;
    sval_t     least, tmp;
    out_word_t r;
    words_taken++;
    if (set_count < CAPACITY) begin
      set_store[set_count] = w.value;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!w.last) return;
    for (i = 0; i < set_count; i++) begin
      least = set_store[i];
      pick  = i;
      for (j = i + 1; j < set_count; j++) begin
        if (set_store[j] < least) begin
          least = set_store[j];
          pick  = j;
        end
      end
      tmp             = set_store[pick];
      set_store[pick] = set_store[i];
      set_store[i]    = tmp;
    end
    for (i = 0; i < set_count; i++) begin
      r.value   = set_store[i];
      r.last    = (i == set_count - 1);
      r.dropped = set_dropped;
      sorted_due_q.push_back(r);
    end
    sets_closed++;
    if (set_dropped) sets_overrun++;
    set_count   = 0;
    set_dropped = 1'b0;
  endfunction

  // Input driver: hold a word until accepted, otherwise idle or send the next one
  always @(posedge clk_i or negedge rst_ni) begin : drv_proc
    in_word_t w;
    logic     hold;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i    <= '0;
      last_in_i  <= 1'b0;
      gap_left   <= 0;
    end else begin
      hold = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        w.value = value_i;
        w.last  = last_in_i;
        take_word(w);
        hold = 1'b0;
      end
      if (!hold) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left   <= $urandom_range(0, GAP_MAX - 1);
          in_valid_i <= 1'b0;
        end else if (pend_q.size() != 0) begin
          w = pend_q.pop_front();
          value_i    <= w.value;
          last_in_i  <= w.last;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output backpressure in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left  <= $urandom_range(0, GAP_MAX - 1);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: compare each accepted sorted word with the oldest prediction
  always @(posedge clk_i) begin : mon_proc
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (sorted_due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0d", $signed(sorted_value_o)));
      end else begin
        want = sorted_due_q.pop_front();
        if (sorted_value_o !== want.value)
          report_mismatch($sformatf("sorted_value got %0d want %0d",
                                    $signed(sorted_value_o), want.value));
        if (last_out_o !== want.last)
          report_mismatch($sformatf("last_out got %b want %b", last_out_o, want.last));
        if (overflowed_o !== want.dropped)
          report_mismatch($sformatf("overflowed got %b want %b",
                                    overflowed_o, want.dropped));
      end
    end
  end

  initial begin : stim_proc
    int    sent, set_idx, size, mode, k;
    sval_t v;

    // Directed: single-word sets at both extremes
    add_word(VAL_MAX, 1'b1);
    add_word(VAL_MIN, 1'b1);
    // Extremes, sign boundary, alternating bit patterns and a duplicate
    add_word('0, 1'b0);
    add_word(-1, 1'b0);
    add_word(VAL_MAX, 1'b0);
    add_word(VAL_MIN, 1'b0);
    add_word(1, 1'b0);
    add_word(-1, 1'b0);
    add_word(sval_t'(32'h5555_5555), 1'b0);
    add_word(sval_t'(32'hAAAA_AAAA), 1'b1);
    // All equal
    add_word(7, 1'b0);
    add_word(7, 1'b0);
    add_word(7, 1'b1);
    // Reversed order
    for (k = 4; k >= 0; k--) add_word(k, k == 0);
    // Already sorted
    add_word(-2, 1'b0);
    add_word(-1, 1'b0);
    add_word(0, 1'b1);

    // Random sets: exact fill, overrun by the closing word, deeper overrun first
    sent    = 0;
    set_idx = 0;
    while (sent < RAND_WORDS) begin
      case (set_idx)
        0: size = CAPACITY;
        1: size = CAPACITY + 1;
        2: size = CAPACITY + 4;
        default: begin
          k = $urandom_range(0, 19);
          if (k == 0)      size = CAPACITY;
          else if (k == 1) size = CAPACITY + 1;
          else if (k == 2) size = $urandom_range(CAPACITY + 2, CAPACITY + 8);
          else if (k < 7)  size = $urandom_range(9, CAPACITY - 1);
          else             size = $urandom_range(1, 8);
        end
      endcase
      mode = $urandom_range(0, 3);
      for (k = 0; k < size; k++) begin
        case (mode)
          2: begin
            // narrow range to force duplicates
            v = $urandom_range(0, 8);
            v = v - 4;
          end
          3: begin
            case ($urandom_range(0, 4))
              0: v = VAL_MIN;
              1: v = VAL_MAX;
              2: v = '0;
              3: v = -1;
              default: v = $urandom();
            endcase
          end
          default: v = $urandom();
        endcase
        add_word(v, k == size - 1);
      end
      sent += size;
      set_idx++;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Run the tail of the stimulus without idle cycles
    while (pend_q.size() > 60) @(posedge clk_i);
    calm <= 1'b1;

    while (pend_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (sorted_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Fed %0d words in %0d sets, %0d of them overran the store",
             words_taken, sets_closed, sets_overrun);
    $display("Checked %0d sorted words, %0d mismatches", results_seen, err_count);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard limit on run time
  initial begin
    #4_000_000;
    $display("Timeout with %0d sorted words still outstanding", sorted_due_q.size());
    $display("simulation failed");
    $finish;
  end

endmodule

### files.f
src/ssu_pkg.sv
src/ssu_store.sv
src/selection_sorter_unit.sv
verif/tb_selection_sorter_unit.sv
